>>> rtl/dirl_pkg.sv
// Shared types, constants and coefficient tables of the dual IR distance linearizer.
`default_nettype none

package dirl_pkg;

    // Input sample and grouping.
    localparam int SAMPLE_W           = 10;
    localparam int SAMPLES_PER_SENSOR = 16;
    localparam int AVG_SHIFT          = $clog2(SAMPLES_PER_SENSOR);
    localparam int SUM_W              = SAMPLE_W + AVG_SHIFT;
    localparam int CNT_W              = $clog2(2 * SAMPLES_PER_SENSOR);

    // Voltage conversion: mv = avg * 3300 / 1023.
    localparam int MV_W      = 12;
    localparam int DIV_W     = SAMPLE_W + MV_W;
    localparam int ADC_SHIFT = 10;
    localparam logic [MV_W-1:0]  MV_FULL  = 12'd3300;
    localparam logic [DIV_W-1:0] ADC_FULL = 22'd1023;

    // Segment selection and distance.
    localparam int SEG_W = 3;
    localparam int FIX_W = 26;
    localparam int FRAC_W = 16;
    localparam int K1_W  = 14;
    localparam int MM_W  = 10;
    localparam int DUTY_W = 7;
    localparam logic [MM_W-1:0] MAX_MM = 10'd600;

    // Duty = (600 - mm) / 5, done as (d * 205) >> 10, exact for d below 1024.
    localparam int DPROD_W    = MM_W + 8;
    localparam int DUTY_SHIFT = 10;
    localparam logic [DPROD_W-1:0] DUTY_RECIP = 18'd205;

    // Segment codes.
    localparam logic [SEG_W-1:0] SEG_A_HIGH = 3'd0;
    localparam logic [SEG_W-1:0] SEG_A_LOW  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_B_HIGH = 3'd2;
    localparam logic [SEG_W-1:0] SEG_B_LOW  = 3'd3;
    localparam logic [SEG_W-1:0] SEG_NONE   = 3'd4;

    // Millivolt band edges.
    localparam logic [MV_W-1:0] BAND_A_TOP = 12'd3300;
    localparam logic [MV_W-1:0] BAND_A_MID = 12'd1900;
    localparam logic [MV_W-1:0] BAND_A_BOT = 12'd90;
    localparam logic [MV_W-1:0] BAND_B_TOP = 12'd3300;
    localparam logic [MV_W-1:0] BAND_B_MID = 12'd1010;
    localparam logic [MV_W-1:0] BAND_B_BOT = 12'd13;

    // Configuration registers.
    localparam int LIM_W = 10;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [LIM_W-1:0] LOW_LIMIT_RST  = 10'd100;
    localparam logic [LIM_W-1:0] HIGH_LIMIT_RST = 10'd580;

    // Stream widths.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [3:0] {
        S_ACC,
        S_CVT_MUL,
        S_CVT_EST,
        S_CVT_FIX,
        S_SEG,
        S_MUL,
        S_DIST,
        S_CLAMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic acc;
        logic grp_end;
        logic cvt_mul;
        logic cvt_est;
        logic cvt_fix;
        logic cvt_to_b;
        logic seg_sel;
        logic k_mul;
        logic dist_upd;
        logic mm_clamp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Q.16 intercept of each segment, in mm.
    function automatic logic [FIX_W-1:0] seg_k0(input logic [1:0] seg);
        logic [FIX_W-1:0] k;
        case (seg)
            2'd0:    k = 26'd14411366;
            2'd1:    k = 26'd19207290;
            2'd2:    k = 26'd34062991;
            2'd3:    k = 26'd38382469;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Q.16 slope of each segment, in mm per mV.
    function automatic logic [K1_W-1:0] seg_k1(input logic [1:0] seg);
        logic [K1_W-1:0] k;
        case (seg)
            2'd0:    k = 14'd2427;
            2'd1:    k = 14'd6517;
            2'd2:    k = 14'd4300;
            2'd3:    k = 14'd8448;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Bands are tested in priority order: A high, A low, B high, B low.
    function automatic logic [SEG_W-1:0] pick_segment(input logic [MV_W-1:0] a_mv,
                                                      input logic [MV_W-1:0] b_mv);
        logic [SEG_W-1:0] s;
        if (a_mv < BAND_A_TOP && a_mv >= BAND_A_MID) begin
            s = SEG_A_HIGH;
        end else if (a_mv < BAND_A_MID && a_mv >= BAND_A_BOT) begin
            s = SEG_A_LOW;
        end else if (b_mv <= BAND_B_TOP && b_mv >= BAND_B_MID) begin
            s = SEG_B_HIGH;
        end else if (b_mv < BAND_B_MID && b_mv >= BAND_B_BOT) begin
            s = SEG_B_LOW;
        end else begin
            s = SEG_NONE;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dirl_ctrl.sv
// Sequencer of the linearizer: sample counting and the conversion step order.
`default_nettype none

module dirl_ctrl
    import dirl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_grp_last;

    assign w_grp_last = (r_count[AVG_SHIFT-1:0] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_count = CNT_W'(r_count + 1'b1);
                    if (w_grp_last) begin
                        o_cmd.grp_end = 1'b1;
                        n_state       = S_CVT_MUL;
                    end else begin
                        o_cmd.acc = 1'b1;
                    end
                end
            end
            S_CVT_MUL: begin
                o_cmd.cvt_mul = 1'b1;
                n_state       = S_CVT_EST;
            end
            S_CVT_EST: begin
                o_cmd.cvt_est = 1'b1;
                n_state       = S_CVT_FIX;
            end
            S_CVT_FIX: begin
                // The count wraps to zero only after the sensor B group.
                o_cmd.cvt_fix  = 1'b1;
                o_cmd.cvt_to_b = (r_count == '0);
                n_state        = (r_count == '0) ? S_SEG : S_ACC;
            end
            S_SEG: begin
                o_cmd.seg_sel = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.k_mul = 1'b1;
                n_state     = S_DIST;
            end
            S_DIST: begin
                o_cmd.dist_upd = 1'b1;
                n_state        = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.mm_clamp = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/dirl_dp.sv
// Datapath of the linearizer: accumulator, mV conversion, segment math and output register.
`default_nettype none

module dirl_dp
    import dirl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    input  wire logic [SAMPLE_W-1:0]    i_sample,
    input  wire logic                   i_cfg_we,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [LIM_W-1:0]       i_cfg_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [MV_W-1:0]             o_a_mv,
    output logic [MV_W-1:0]             o_b_mv,
    output logic [SEG_W-1:0]            o_segment,
    output logic [MM_W-1:0]             o_distance_mm,
    output logic                        o_in_range,
    output logic [DUTY_W-1:0]           o_duty
);

    logic [LIM_W-1:0]    r_low_limit, r_high_limit;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_avg;
    logic [DIV_W-1:0]    r_x;
    logic [MV_W-1:0]     r_q;
    logic [MV_W-1:0]     r_a_mv, r_b_mv, r_mv_sel;
    logic [SEG_W-1:0]    r_seg;
    logic [FIX_W-1:0]    r_k0, r_prod, r_held;
    logic [K1_W-1:0]     r_k1;
    logic [MM_W-1:0]     r_mm;
    logic                r_out_valid;

    logic [SUM_W-1:0]    w_sum_next;
    logic [DIV_W-1:0]    w_est, w_rem;
    logic [MV_W-1:0]     w_mv;
    logic [SEG_W-1:0]    w_seg;
    logic [MM_W-1:0]     w_mm_raw, w_span;
    logic [DPROD_W-1:0]  w_dprod;

    assign w_sum_next = r_sum + SUM_W'(i_sample);

    // Reciprocal estimate of x / 1023 is at most one low; one compare fixes it.
    assign w_est = (r_x + (r_x >> ADC_SHIFT)) >> ADC_SHIFT;
    assign w_rem = r_x - ((DIV_W'(r_q) << ADC_SHIFT) - DIV_W'(r_q));
    assign w_mv  = r_q + MV_W'(w_rem >= ADC_FULL);

    assign w_seg    = pick_segment(r_a_mv, r_b_mv);
    assign w_mm_raw = r_held[FIX_W-1:FRAC_W];
    assign w_span   = MAX_MM - r_mm;
    assign w_dprod  = DPROD_W'(w_span) * DUTY_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                REG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum <= w_sum_next;
            end else if (i_cmd.grp_end) begin
                r_sum <= '0;
            end
            if (i_cmd.dist_upd && r_seg != SEG_NONE) begin
                r_held <= (r_k0 >= r_prod) ? (r_k0 - r_prod) : '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grp_end) begin
            r_avg <= w_sum_next[SUM_W-1:AVG_SHIFT];
        end
        if (i_cmd.cvt_mul) begin
            r_x <= DIV_W'(r_avg) * DIV_W'(MV_FULL);
        end
        if (i_cmd.cvt_est) begin
            r_q <= w_est[MV_W-1:0];
        end
        if (i_cmd.cvt_fix) begin
            if (i_cmd.cvt_to_b) begin
                r_b_mv <= w_mv;
            end else begin
                r_a_mv <= w_mv;
            end
        end
        if (i_cmd.seg_sel) begin
            r_seg    <= w_seg;
            r_k0     <= seg_k0(w_seg[1:0]);
            r_k1     <= seg_k1(w_seg[1:0]);
            r_mv_sel <= (w_seg == SEG_A_HIGH || w_seg == SEG_A_LOW) ? r_a_mv : r_b_mv;
        end
        if (i_cmd.k_mul) begin
            r_prod <= FIX_W'(r_k1) * FIX_W'(r_mv_sel);
        end
        if (i_cmd.mm_clamp) begin
            r_mm <= (w_mm_raw > MAX_MM) ? MAX_MM : w_mm_raw;
        end
        if (i_cmd.out_load) begin
            o_a_mv        <= r_a_mv;
            o_b_mv        <= r_b_mv;
            o_segment     <= r_seg;
            o_distance_mm <= r_mm;
            o_in_range    <= (r_mm >= r_low_limit) && (r_mm < r_high_limit);
            o_duty        <= DUTY_W'(w_dprod >> DUTY_SHIFT);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> rtl/dual_ir_distance_linearizer.sv
// Top level of the dual IR distance linearizer: ports, controller, datapath and checks.
`default_nettype none

// The block takes 10-bit ADC samples on the input stream, sixteen from sensor A
// followed by sixteen from sensor B, and after every thirty-second sample it sends
// one item on the output stream. Each group is averaged (sum divided by sixteen,
// truncated) and scaled to millivolts as avg * 3300 / 1023, truncated. The first
// matching band of the four (A from 1900 to below 3300 mV, A from 90 to below 1900,
// B from 1010 to 3300, B from 13 to below 1010) picks a straight-line segment, and the
// distance is (K0 - K1 * mv) >> 16 with Q.16 coefficients. When no band matches, the
// segment code is 4 and the last distance (zero after reset) is repeated. The
// distance is limited to 600 mm; in_range is set when it lies at or above the low
// limit and below the high limit, and duty is (600 - distance) / 5. Sample items are
// accepted back to back while the block accumulates. After the sixteenth sample the
// input pauses while the shared divide-by-1023 conversion runs (multiply, estimate,
// correction); after the thirty-second it pauses for the conversion, segment pick, the
// coefficient multiplier, the distance update, clamping and the output load.
// The pause grows if the previous result item has not yet been taken from the output
// register. The two limit registers are written through the configuration channel
// (index 0 low limit, index 1 high limit, other indexes ignored); write them only
// while no run is in progress.

module dual_ir_distance_linearizer
    import dirl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] sample_raw, [15:10] zero
    // Output stream.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [11:0] sensor_a_mv,
                                                     // [23:12] sensor_b_mv,
                                                     // [26:24] segment,
                                                     // [36:27] distance_mm,
                                                     // [37] in_range, [44:38] duty,
                                                     // [47:45] zero
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [LIM_W-1:0]       i_cfg_data
);

    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic [MV_W-1:0]     w_a_mv, w_b_mv;
    logic [SEG_W-1:0]    w_segment;
    logic [MM_W-1:0]     w_distance_mm;
    logic                w_in_range;
    logic [DUTY_W-1:0]   w_duty;

    // Register writes never stall.
    assign o_cfg_ready = 1'b1;

    dirl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dirl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample      (i_s_tdata[SAMPLE_W-1:0]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_a_mv        (w_a_mv),
        .o_b_mv        (w_b_mv),
        .o_segment     (w_segment),
        .o_distance_mm (w_distance_mm),
        .o_in_range    (w_in_range),
        .o_duty        (w_duty)
    );

    // The fields are packed from the lowest bit up; the top bits are padding.
    assign o_m_tdata = {3'b000, w_duty, w_in_range, w_distance_mm, w_segment,
                        w_b_mv, w_a_mv};

    // A result loaded by the sequencer shows up as a valid output item.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_m_tvalid)
        else $error("loaded result did not appear on the output");

    // The last sample of a group always starts a conversion, which pauses the input.
    a_group_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.grp_end |=> !o_s_tready)
        else $error("input not paused during conversion");

    // Duty agrees with the distance: 5 * duty <= 600 - mm < 5 * duty + 5.
    a_duty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ((11'(w_distance_mm) + 11'(w_duty) * 11'd5) <= 11'd600) &&
            ((11'(w_distance_mm) + 11'(w_duty) * 11'd5 + 11'd5) > 11'd600))
        else $error("duty does not match distance");

    // A distance above 600 mm or a segment code above 4 never leaves the block.
    a_dist_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_distance_mm <= MAX_MM) && (w_segment <= SEG_NONE))
        else $error("distance or segment out of bounds");

endmodule

`default_nettype wire
